/* hw/rtl/hhr_pkg.sv */
// ----------------------------------------------------------------------------
// hhr_pkg
// Shared codes for the heat-map HSV to RGB unit: configuration register
// indexes, hue scale constants and the colour-wheel sector type.
// ----------------------------------------------------------------------------
package hhr_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b1;

  // H' = (1 - level) * 0.65 * 360 / 60 = (1 - level) * 39 / 10
  localparam int unsigned HUE_NUM = 39;
  localparam int unsigned HUE_DEN = 10;

  // integer part of H', one code per 60 degree sector
  localparam int unsigned SECTOR_W = 3;
  typedef enum logic [SECTOR_W-1:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5,
    SEC_OUT_A         = 3'd6,
    SEC_OUT_B         = 3'd7
  } sector_t;

endpackage

/* hw/rtl/hhr_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// hhr_pipe_ctrl
// Valid bits and load enables for the stall-able pipeline. A stage loads
// when it is empty or when the stage after it moves on.
// ----------------------------------------------------------------------------
module hhr_pipe_ctrl #(
  parameter int unsigned NUM_STAGES = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  out_stall,
  output logic [NUM_STAGES-1:0] ld,
  output logic                  out_valid
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;

  always_comb begin
    ld[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (ld[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

/* hw/rtl/hhr_hue_path.sv */
// ----------------------------------------------------------------------------
// hhr_hue_path
// Hue side, three stages: clamp and scale by 39, divide by 10 through a
// reciprocal multiply, then correct the quotient and fold it into sector
// and ramp factor 1 - |H' mod 2 - 1|.
// ----------------------------------------------------------------------------
module hhr_hue_path #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic [2:0]                            ld,
  input  logic [FRAC_BITS:0]                    level,
  output hhr_pkg::sector_t                      sector,
  output logic [FRAC_BITS:0]                    fac
);
  import hhr_pkg::*;

  localparam int unsigned W   = FRAC_BITS + 1;
  localparam int unsigned NB  = FRAC_BITS + 6;   // holds 39 * ONE
  localparam int unsigned SH  = NB + 4;
  localparam int unsigned RB  = NB + 1;
  localparam int unsigned QB  = NB - 3;          // holds H' (below 4 * ONE)
  localparam logic [RB-1:0] RECIP = RB'((64'd1 << SH) / 64'(HUE_DEN));
  localparam logic [W-1:0]  ONE   = {1'b1, {FRAC_BITS{1'b0}}};

  // stage 0
  logic [W-1:0]  lvl;
  logic [W-1:0]  dist0;
  logic [NB-1:0] n0_r;

  assign lvl   = (level > ONE) ? ONE : level;
  assign dist0 = ONE - lvl;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      n0_r <= NB'(dist0) * NB'(HUE_NUM);
    end
  end

  // stage 1: quotient estimate, low by at most one
  logic [NB+RB-1:0] prod1;
  logic [QB-1:0]    q1_r;
  logic [NB-1:0]    n1_r;

  assign prod1 = (NB+RB)'(n0_r) * (NB+RB)'(RECIP);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      q1_r <= prod1[NB+RB-1:SH];
      n1_r <= n0_r;
    end
  end

  // stage 2: correction and fold
  logic [NB-1:0] rem2;
  logic [QB-1:0] hp2;
  logic [W-1:0]  m2;
  logic [W-1:0]  dist2;
  sector_t       sector_r;
  logic [W-1:0]  fac_r;

  assign rem2  = n1_r - NB'(q1_r) * NB'(HUE_DEN);
  assign hp2   = (rem2 >= NB'(HUE_DEN)) ? q1_r + QB'(1) : q1_r;
  assign m2    = hp2[FRAC_BITS:0];
  assign dist2 = (m2 >= ONE) ? m2 - ONE : ONE - m2;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      sector_r <= sector_t'(hp2[FRAC_BITS+2:FRAC_BITS]);
      fac_r    <= ONE - dist2;
    end
  end

  assign sector = sector_r;
  assign fac    = fac_r;

endmodule

/* hw/rtl/hhr_rgb_mix.sv */
// ----------------------------------------------------------------------------
// hhr_rgb_mix
// Chroma side: C = V*S, M = V - C, X = C * factor, then the six-sector
// placement plus offset into the output registers.
// ----------------------------------------------------------------------------
module hhr_rgb_mix #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic [4:0]               ld,
  input  logic [FRAC_BITS:0]       sat,
  input  logic [FRAC_BITS:0]       bri,
  input  hhr_pkg::sector_t         sector,
  input  logic [FRAC_BITS:0]       fac,
  output logic [FRAC_BITS:0]       red,
  output logic [FRAC_BITS:0]       green,
  output logic [FRAC_BITS:0]       blue
);
  import hhr_pkg::*;

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage 0: clamp registers and multiply
  logic [W-1:0]   s0;
  logic [W-1:0]   v0;
  logic [2*W-1:0] vs0_r;
  logic [W-1:0]   v0_r;

  assign s0 = (sat > ONE) ? ONE : sat;
  assign v0 = (bri > ONE) ? ONE : bri;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      vs0_r <= (2*W)'(v0) * (2*W)'(s0);
      v0_r  <= v0;
    end
  end

  // stage 1: chroma and offset
  logic [W-1:0] c1;
  logic [W-1:0] c1_r;
  logic [W-1:0] m1_r;

  assign c1 = vs0_r[FRAC_BITS+W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      c1_r <= c1;
      m1_r <= v0_r - c1;
    end
  end

  // stage 2: wait for the hue side
  logic [W-1:0] c2_r;
  logic [W-1:0] m2_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      c2_r <= c1_r;
      m2_r <= m1_r;
    end
  end

  // stage 3: secondary component
  logic [2*W-1:0] cx3;
  logic [W-1:0]   x3_r;
  logic [W-1:0]   c3_r;
  logic [W-1:0]   m3_r;
  sector_t        sec3_r;

  assign cx3 = (2*W)'(c2_r) * (2*W)'(fac);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      x3_r   <= cx3[FRAC_BITS+W-1:FRAC_BITS];
      c3_r   <= c2_r;
      m3_r   <= m2_r;
      sec3_r <= sector;
    end
  end

  // stage 4: placement and offset
  logic [W-1:0] r4;
  logic [W-1:0] g4;
  logic [W-1:0] b4;
  logic [W-1:0] red_r;
  logic [W-1:0] green_r;
  logic [W-1:0] blue_r;

  always_comb begin
    r4 = '0;
    g4 = '0;
    b4 = '0;
    unique case (sec3_r)
      SEC_RED_YELLOW: begin
        r4 = c3_r;
        g4 = x3_r;
      end
      SEC_YELLOW_GREEN: begin
        r4 = x3_r;
        g4 = c3_r;
      end
      SEC_GREEN_CYAN: begin
        g4 = c3_r;
        b4 = x3_r;
      end
      SEC_CYAN_BLUE: begin
        g4 = x3_r;
        b4 = c3_r;
      end
      SEC_BLUE_MAGENTA: begin
        r4 = x3_r;
        b4 = c3_r;
      end
      SEC_MAGENTA_RED: begin
        r4 = c3_r;
        b4 = x3_r;
      end
      default: begin
        // outside the wheel: grey at the offset level
        r4 = '0;
        g4 = '0;
        b4 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      red_r   <= r4 + m3_r;
      green_r <= g4 + m3_r;
      blue_r  <= b4 + m3_r;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

/* hw/rtl/hsv_heatmap_to_rgb_unit.sv */
// ----------------------------------------------------------------------------
// hsv_heatmap_to_rgb_unit
// Maps a Q(FRAC_BITS) level in 0..1 to a heat-map RGB colour through HSV.
// ----------------------------------------------------------------------------
// Takes one level per clock while in_stall is low; the
// five register stages (clamp, scale by 39 and V*S, reciprocal divide and
// chroma, quotient correction and hue fold, chroma times ramp, sector
// placement into the output register) each hold one transaction, so
// out_stall only holds the pipe back once it is full. Saturation and
// brightness are to be written through the cfg port only while no
// transaction is in flight, which the block itself does not enforce;
// values above 1.0 are kept but used as 1.0, and both reset to about 0.8.
// ----------------------------------------------------------------------------
module hsv_heatmap_to_rgb_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [FRAC_BITS:0]             in_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [FRAC_BITS:0]             out_red,
  output logic [FRAC_BITS:0]             out_green,
  output logic [FRAC_BITS:0]             out_blue,
  input  logic                           cfg_we,
  input  logic [hhr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [FRAC_BITS:0]             cfg_wdata
);
  import hhr_pkg::*;

  localparam int unsigned W = FRAC_BITS + 1;
  localparam int unsigned NUM_STAGES = 5;
  // about 0.8, 52429 at Q16
  localparam logic [W-1:0] RESET_LEVEL = W'((64'd4 << FRAC_BITS) / 64'd5 + 64'd1);

  logic [W-1:0] sat_r;
  logic [W-1:0] bri_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= RESET_LEVEL;
      bri_r <= RESET_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SATURATION: sat_r <= cfg_wdata;
        CFG_BRIGHTNESS: bri_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [NUM_STAGES-1:0] ld;
  sector_t               sector;
  logic [W-1:0]          fac;

  hhr_pipe_ctrl #(
    .NUM_STAGES (NUM_STAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .ld        (ld),
    .out_valid (out_valid)
  );

  hhr_hue_path #(
    .FRAC_BITS (FRAC_BITS)
  ) u_hue (
    .clk    (clk),
    .ld     (ld[2:0]),
    .level  (in_level),
    .sector (sector),
    .fac    (fac)
  );

  hhr_rgb_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk    (clk),
    .ld     (ld),
    .sat    (sat_r),
    .bri    (bri_r),
    .sector (sector),
    .fac    (fac),
    .red    (out_red),
    .green  (out_green),
    .blue   (out_blue)
  );

endmodule
